/* src/sha512_pkg.sv */
// Package for the SHA-512/384 hash core: round constants, initial values,
// helper functions and the front-to-back request type. No dependencies.
package sha512_pkg;

    localparam int WORD_W    = 64;
    localparam int ROUNDS    = 80;
    localparam int QDEPTH    = 4;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] LENGTH_SLOT = 4'd14;

    // request from front to back: a word to push, optionally the last of a message
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;  // saturated to 8
        logic        last;
    } sha_req_t;

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] k;
        case (i)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] init_hash(input logic mode, input logic [2:0] i);
        logic [63:0] v;
        case ({mode, i})
            4'd0: v = 64'hcbbb9d5dc1059ed8; 4'd1: v = 64'h629a292a367cd507;
            4'd2: v = 64'h9159015a3070dd17; 4'd3: v = 64'h152fecd8f70e5939;
            4'd4: v = 64'h67332667ffc00b31; 4'd5: v = 64'h8eb44a8768581511;
            4'd6: v = 64'hdb0c2e0d64f98fa7; 4'd7: v = 64'h47b5481dbefa4fa4;
            4'd8: v = 64'h6a09e667f3bcc908; 4'd9: v = 64'hbb67ae8584caa73b;
            4'd10: v = 64'h3c6ef372fe94f82b; 4'd11: v = 64'ha54ff53a5f1d36f1;
            4'd12: v = 64'h510e527fade682d1; 4'd13: v = 64'h9b05688c2b3e6c1f;
            4'd14: v = 64'h1f83d9abfb41bd6b; 4'd15: v = 64'h5be0cd19137e2179;
            default: v = 64'h0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

/* src/sha512_front.sv */
// Front end of the SHA-512 core: accepts stream words, saturates the byte
// count and queues requests for the back end. Depends on sha512_pkg.
module sha512_front import sha512_pkg::*; #(
    parameter int QD = QDEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        flush,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tlast,
    output logic        q_valid,
    input  logic        q_ready,
    output sha_req_t    q_req
);
    localparam int AW = $clog2(QD);

    sha_req_t             mem [QD];
    logic [AW-1:0]        wr_reg, rd_reg;
    logic [AW:0]          cnt_reg;
    sha_req_t             req_in;
    logic                 push, pop;

    always_comb begin
        req_in.word   = s_tdata[63:0];
        req_in.nbytes = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
        req_in.last   = s_tlast;
    end

    assign s_tready = (cnt_reg != (AW+1)'(QD));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_req    = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= req_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

/* src/sha512_back.sv */
// Back end of the SHA-512 core: window fill, padding, 80-round compression
// and digest output. Depends on sha512_pkg.
module sha512_back import sha512_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_mode,
    input  logic        q_valid,
    output logic        q_ready,
    input  sha_req_t    q_req,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    output logic        busy
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PUSH2 = 6'b000010,  // pad word after a full last word
        ST_PAD   = 6'b000100,  // zero/length fill
        ST_COMP  = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t       state_reg, ret_reg;
    logic         mode_reg;
    logic [63:0]  h_reg [8];
    logic [63:0]  v_reg [8];
    logic [63:0]  w_reg [16];
    logic [3:0]   pos_reg;
    logic [6:0]   rnd_reg;
    logic [63:0]  cnt_lo_reg;
    logic [60:0]  cnt_hi_reg;
    logic         padding_reg;   // in the final pad of a message
    logic         len_hi_done_reg;  // upper length word already in the window
    logic [2:0]   out_idx_reg;

    logic         do_push;
    logic [63:0]  push_word;
    logic [63:0]  first_word, mask;
    logic [64:0]  lo_sum;
    logic [63:0]  w2, w15, wnew, wcur, t1, t2, e, a;
    logic [3:0]   s;
    logic [2:0]   last_idx;

    assign last_idx = mode_reg ? 3'd7 : 3'd5;
    assign q_ready  = (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);

    always_comb begin
        mask = (q_req.nbytes == 4'd0) ? 64'h0 : ~(64'h0) << (7'd64 - {q_req.nbytes, 3'b000});
        first_word = (q_req.word & mask) | ({56'h0, PAD_BYTE} << (7'd56 - {q_req.nbytes, 3'b000}));
        if (q_req.nbytes == 4'd8) first_word = q_req.word;
        lo_sum = {1'b0, cnt_lo_reg} + {60'h0, (q_req.last ? q_req.nbytes : 4'd8)};
    end

    // schedule and round datapath
    always_comb begin
        s    = rnd_reg[3:0];
        w2   = w_reg[s + 4'd14];
        w15  = w_reg[s + 4'd1];
        wnew = (rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6)) + w_reg[s + 4'd9]
             + (rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7)) + w_reg[s];
        wcur = (rnd_reg >= 7'd16) ? wnew : w_reg[s];
        e    = v_reg[4];
        a    = v_reg[0];
        t1   = v_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(rnd_reg) + wcur;
        t2   = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        do_push   = 1'b0;
        push_word = 64'h0;
        case (state_reg)
            ST_IDLE: begin
                do_push   = q_valid;
                push_word = q_req.last ? first_word : q_req.word;
            end
            ST_PUSH2: begin
                do_push   = 1'b1;
                push_word = {PAD_BYTE, 56'h0};
            end
            ST_PAD: begin
                do_push = 1'b1;
                if (pos_reg == LENGTH_SLOT) push_word = {cnt_hi_reg, cnt_lo_reg[63:61]};
                else if (pos_reg == 4'd15 && len_hi_done_reg)
                    push_word = {cnt_lo_reg[60:0], 3'b000};
                else                        push_word = 64'h0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) w_reg[pos_reg] <= push_word;
        else if (state_reg == ST_COMP && rnd_reg >= 7'd16) w_reg[s] <= wnew;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            mode_reg    <= aresetn ? cfg_mode : 1'b1;
            pos_reg     <= '0;
            rnd_reg     <= '0;
            cnt_lo_reg  <= '0;
            cnt_hi_reg  <= '0;
            padding_reg <= 1'b0;
            len_hi_done_reg <= 1'b0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= init_hash(aresetn ? cfg_mode : 1'b1, 3'(i));
                if (!aresetn) v_reg[i] <= '0;
            end
        end else begin
            if (do_push) pos_reg <= pos_reg + 4'd1;
            case (state_reg)
                ST_IDLE: if (q_valid) begin
                    cnt_lo_reg <= lo_sum[63:0];
                    if (lo_sum[64]) cnt_hi_reg <= cnt_hi_reg + 61'd1;
                    padding_reg <= q_req.last;
                    if (q_req.last && q_req.nbytes == 4'd8) ret_reg <= ST_PUSH2;
                    else if (q_req.last) ret_reg <= ST_PAD;
                    else ret_reg <= ST_IDLE;
                    if (pos_reg == 4'd15) state_reg <= ST_COMP;
                    else if (q_req.last && q_req.nbytes == 4'd8) state_reg <= ST_PUSH2;
                    else if (q_req.last) state_reg <= ST_PAD;
                end
                ST_PUSH2: begin
                    ret_reg   <= ST_PAD;
                    state_reg <= (pos_reg == 4'd15) ? ST_COMP : ST_PAD;
                end
                ST_PAD: begin
                    if (pos_reg == LENGTH_SLOT) len_hi_done_reg <= 1'b1;
                    // slot 15 ends the message only once the length is in place
                    ret_reg <= (pos_reg == 4'd15 && len_hi_done_reg) ? ST_OUT : ST_PAD;
                    if (pos_reg == 4'd15) state_reg <= ST_COMP;
                end
                ST_COMP: begin
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    if (rnd_reg == 7'(ROUNDS - 1)) begin
                        rnd_reg   <= '0;
                        state_reg <= ST_ADD;
                    end else begin
                        rnd_reg <= rnd_reg + 7'd1;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    state_reg <= ret_reg;
                end
                ST_OUT: if (m_tready) begin
                    if (out_idx_reg == last_idx) begin
                        out_idx_reg <= '0;
                        state_reg   <= ST_IDLE;
                        ret_reg     <= ST_IDLE;
                        pos_reg     <= '0;
                        cnt_lo_reg  <= '0;
                        cnt_hi_reg  <= '0;
                        padding_reg <= 1'b0;
                        len_hi_done_reg <= 1'b0;
                        for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(mode_reg, 3'(i));
                    end else begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // load working variables at the start of a compression
            if (state_reg != ST_COMP && state_reg != ST_ADD && do_push && pos_reg == 4'd15)
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = h_reg[out_idx_reg];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == last_idx) && padding_reg;
endmodule

/* src/sha512_hash_core.sv */
// Top level of the SHA-512/384 hash core: front request queue and back end.
// Depends on sha512_pkg, sha512_front, sha512_back.
//
//  channel   dir  payload
//  s_*       in   tdata[63:0] message_word, tdata[67:64] valid_bytes, tlast end_of_message
//  m_*       out  tdata digest_word, tuser word_number, tlast final_word
//  cfg_*     in   cfg_wdata[0] digest_mode
//
// A word is stored in the window while the back end is idle; every 16th window
// word starts a compression in ST_COMP followed by a feed-forward add in ST_ADD.
// The last word adds pad words and may need one extra block, then one digest
// word per cycle while m_tready is high. Reset is synchronous; the queue holds
// QD requests so the stream side takes words during a compression until full.
module sha512_hash_core import sha512_pkg::*; #(
    parameter int QD = QDEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] message_word, [67:64] valid_bytes
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_number
    output logic        m_tlast
);
    logic     q_valid, q_ready, busy;
    sha_req_t q_req;

    sha512_front #(.QD(QD)) u_front (
        .aclk, .aresetn, .flush(cfg_we), .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .q_valid, .q_ready, .q_req
    );

    sha512_back u_back (
        .aclk, .aresetn, .cfg_we, .cfg_mode(cfg_wdata), .q_valid, .q_ready, .q_req,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast, .busy
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn || cfg_we)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
        else $error("digest word dropped while stalled");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !q_ready)
        else $error("request taken while back end busy");
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser == 3'd5 || m_tuser == 3'd7))
        else $error("final word at wrong position");
`endif
endmodule
